[hw/rtl/psg_pkg.sv]
// Shared types, constants and table functions of the three-voice sound generator.
package psg_pkg;

   // Item actions
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_READ   = 2'd1;
   localparam logic [1:0] ACT_RENDER = 2'd2;

   // Register numbers with side effects
   localparam logic [3:0] REG_NOISE  = 4'd6;
   localparam logic [3:0] REG_MIXER  = 4'd7;
   localparam logic [3:0] REG_VOL_A  = 4'd8;
   localparam logic [3:0] REG_ENV_LO = 4'd11;
   localparam logic [3:0] REG_ENV_HI = 4'd12;
   localparam logic [3:0] REG_SHAPE  = 4'd13;

   // Field widths
   localparam int BURST_W  = 7;
   localparam int PER_W    = 31;
   localparam int DIV_W    = 15;
   localparam int AREA_W   = 17;
   localparam int VOL_W    = 14;
   localparam int LFSR_W   = 17;

   localparam logic [15:0]       STEP_RESET = 16'd7710;
   localparam logic [15:0]       SUB_STEPS  = 16'h8000;
   localparam logic [PER_W-1:0]  PER_MAX    = {PER_W{1'b1}};
   localparam logic [LFSR_W:0]   LFSR_TAPS  = 18'h24000;
   localparam logic [13:0]       VOL_PEAK   = 14'd10922;
   localparam logic signed [16:0] DC_COEF   = 17'sd4076;
   localparam int                DC_SHIFT   = 12;
   localparam int                MAX_BURST_DEF = 64;

   // Envelope flag bits
   localparam int EF_HOLD    = 0;
   localparam int EF_ALT     = 1;
   localparam int EF_ATTACK  = 2;
   localparam int EF_HOLDING = 3;

   typedef struct packed {
      logic [1:0]         action;
      logic [3:0]         reg_addr;
      logic [7:0]         write_data;
      logic [BURST_W-1:0] sample_count;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic [7:0]         read_data;
      logic               is_read;
      logic               last;
   } rsp_item_type;

   // Logarithmic volume, 1.5 dB a step
   function automatic logic [VOL_W-1:0] vol_lookup(input logic [4:0] idx);
      logic [VOL_W-1:0] v;
      case (idx)
         5'd0:  v = 14'd0;     5'd1:  v = 14'd61;    5'd2:  v = 14'd73;
         5'd3:  v = 14'd87;    5'd4:  v = 14'd103;   5'd5:  v = 14'd123;
         5'd6:  v = 14'd146;   5'd7:  v = 14'd173;   5'd8:  v = 14'd206;
         5'd9:  v = 14'd245;   5'd10: v = 14'd291;   5'd11: v = 14'd345;
         5'd12: v = 14'd410;   5'd13: v = 14'd488;   5'd14: v = 14'd580;
         5'd15: v = 14'd689;   5'd16: v = 14'd819;   5'd17: v = 14'd973;
         5'd18: v = 14'd1157;  5'd19: v = 14'd1375;  5'd20: v = 14'd1634;
         5'd21: v = 14'd1942;  5'd22: v = 14'd2308;  5'd23: v = 14'd2743;
         5'd24: v = 14'd3261;  5'd25: v = 14'd3875;  5'd26: v = 14'd4606;
         5'd27: v = 14'd5474;  5'd28: v = 14'd6506;  5'd29: v = 14'd7732;
         5'd30: v = 14'd9190;  5'd31: v = 14'd10922;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

   // Bits kept by each register
   function automatic logic [7:0] reg_mask(input logic [3:0] addr);
      logic [7:0] m;
      case (addr) inside
         4'd1, 4'd3, 4'd5, REG_SHAPE:   m = 8'h0f;
         REG_NOISE, [4'd8:4'd10]:       m = 8'h1f;
         default:                       m = 8'hff;
      endcase
      return m;
   endfunction

   // Counter after a period change, limited to 1..PER_MAX
   function automatic logic [PER_W-1:0] retune_count(input logic [PER_W-1:0] cnt,
                                                     input logic [PER_W-1:0] per_old,
                                                     input logic [PER_W-1:0] per_new);
      logic signed [PER_W+2:0] s;
      logic [PER_W-1:0]        r;
      s = $signed({3'b0, cnt}) + $signed({3'b0, per_new}) - $signed({3'b0, per_old});
      if (s < 1)
         r = {{(PER_W-1){1'b0}}, 1'b1};
      else if (s > $signed({3'b0, PER_MAX}))
         r = PER_MAX;
      else
         r = s[PER_W-1:0];
      return r;
   endfunction

endpackage

[hw/rtl/psg_div.sv]
// Shared restoring divider: one quotient bit a cycle.
module psg_div import psg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [PER_W-1:0]   divisor,
   output logic               done,
   output logic [DIV_W-1:0]   quotient,
   output logic [PER_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(DIV_W);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DIV_W-1:0]   q_ff;
   logic [PER_W-1:0]   r_ff;
   logic [PER_W-1:0]   dsr_ff;

   logic [PER_W:0]     trial;
   logic               ge;
   logic [PER_W:0]     diff;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      trial = {r_ff, q_ff[DIV_W-1]};
      ge    = trial >= {1'b0, dsr_ff};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W - 1);
            q_ff    <= dividend;
            r_ff    <= '0;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            r_ff <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
            q_ff <= {q_ff[DIV_W-2:0], ge};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

[hw/rtl/psg_core.sv]
// Sound generator state, sequencer and shared multiplier datapath.
module psg_core import psg_pkg::*; #(
   parameter int MAX_BURST = MAX_BURST_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data,
   input  logic          start,
   input  req_item_type  req,
   output logic          idle,
   output logic          res_valid,
   input  logic          res_ready,
   output rsp_item_type  res
);

   typedef enum logic [3:0] {
      S_IDLE, S_WR_MUL, S_WR_APPLY, S_EV, S_CH, S_CH_DIV, S_NOISE,
      S_ENV, S_ENV_DIV, S_MIX, S_DC, S_DCY, S_EMIT
   } state_type;

   state_type          state_ff;
   logic [15:0]        step_ff;
   logic [7:0]         regs_ff [16];
   logic [PER_W-1:0]   tper_ff [3];
   logic [PER_W-1:0]   tcnt_ff [3];
   logic [2:0]         tlvl_ff;
   logic [PER_W-1:0]   nper_ff;
   logic [PER_W-1:0]   ncnt_ff;
   logic               nlvl_ff;
   logic [LFSR_W-1:0]  lfsr_ff;
   logic [PER_W-1:0]   eper_ff;
   logic [PER_W-1:0]   ecnt_ff;
   logic [4:0]         estep_ff;
   logic [3:0]         eflag_ff;
   logic [VOL_W-1:0]   vol_ff [4];
   logic [2:0]         usenv_ff;
   logic [15:0]        dcx_ff;
   logic signed [23:0] dcy_ff;

   logic [3:0]         addr_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [15:0]        ev_ff;
   logic [15:0]        left_ff;
   logic [1:0]         ch_ff;
   logic [AREA_W-1:0]  area_ff [3];
   logic signed [32:0] c_ff;
   logic [31:0]        macc_ff;
   logic [1:0]         mix_ff;
   rsp_item_type       res_ff;
   logic signed [41:0] mul_ff;

   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic [PER_W-1:0]   div_divisor;
   logic               div_done;
   logic [DIV_W-1:0]   div_q;
   logic [PER_W-1:0]   div_r;

   // Reset and scale-change values
   logic [15:0]        init_step;
   logic [PER_W-1:0]   init_per;
   logic [PER_W-1:0]   init_eper;

   always_comb begin
      if (reset)
         init_step = STEP_RESET;
      else if (csr_wr_data == '0)
         init_step = 16'd1;
      else
         init_step = csr_wr_data;
      init_per  = {{(PER_W-16){1'b0}}, init_step};
      init_eper = (init_step[15:1] == '0) ? {{(PER_W-1){1'b0}}, 1'b1}
                                          : {{(PER_W-15){1'b0}}, init_step[15:1]};
   end

   // Shared multiplier operands
   logic signed [24:0] mul_a;
   logic signed [16:0] mul_b;
   logic [2:0]         wr_ch;

   assign wr_ch = {1'b0, addr_ff[2:1]};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_WR_MUL: begin
            mul_b = {1'b0, step_ff};
            case (addr_ff) inside
               [4'd0:4'd5]: mul_a = {13'b0, regs_ff[{wr_ch, 1'b1}][3:0],
                                     regs_ff[{wr_ch, 1'b0}]};
               REG_NOISE:   mul_a = {17'b0, regs_ff[REG_NOISE]};
               default:     mul_a = {9'b0, regs_ff[REG_ENV_HI], regs_ff[REG_ENV_LO]};
            endcase
         end
         S_MIX: begin
            if (mix_ff != 2'd3) begin
               mul_a = {8'b0, area_ff[mix_ff]};
               mul_b = {3'b0, vol_ff[mix_ff]};
            end
         end
         S_DC: begin
            mul_a = {dcy_ff[23], dcy_ff};
            mul_b = DC_COEF;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // Period updates after a register write
   logic [32:0]        prod_u;
   logic [PER_W-1:0]   tone_p;
   logic [PER_W-1:0]   env_p;
   logic [4:0]         vol_reg;
   logic [3:0]         shape;
   logic [3:0]         shape_flags;

   always_comb begin
      prod_u = mul_ff[32:0];
      tone_p = (prod_u == '0) ? {{(PER_W-16){1'b0}}, step_ff} : prod_u[PER_W-1:0];
      if (prod_u == '0)
         env_p = (step_ff[15:1] == '0) ? {{(PER_W-1){1'b0}}, 1'b1}
                                       : {{(PER_W-15){1'b0}}, step_ff[15:1]};
      else if (prod_u > {2'b0, PER_MAX})
         env_p = PER_MAX;
      else
         env_p = prod_u[PER_W-1:0];
      vol_reg = regs_ff[addr_ff][4:0];
      shape   = regs_ff[REG_SHAPE][3:0];
      shape_flags = '0;
      shape_flags[EF_ATTACK] = shape[2];
      if (!shape[3]) begin
         shape_flags[EF_HOLD] = 1'b1;
         shape_flags[EF_ALT]  = shape[2];
      end else begin
         shape_flags[EF_HOLD] = shape[0];
         shape_flags[EF_ALT]  = shape[1];
      end
   end

   // Burst start
   logic [BURST_W-1:0] burst_n;
   logic [21:0]        burst_len;

   always_comb begin
      burst_n   = (req.sample_count > BURST_W'(MAX_BURST)) ? BURST_W'(MAX_BURST)
                                                           : req.sample_count;
      burst_len = {burst_n, 15'b0};
   end

   // One tone channel over one noise event
   logic [PER_W-1:0]   cur_cnt;
   logic [PER_W-1:0]   cur_per;
   logic               cur_lvl;
   logic               gate;
   logic signed [32:0] c_cmb;
   logic [PER_W-1:0]   cf;
   logic               qodd;
   logic               new_lvl;
   logic signed [34:0] cnt_s, per_s, cf_s, c_s, dd, pp, net;

   always_comb begin
      cur_cnt = tcnt_ff[ch_ff];
      cur_per = tper_ff[ch_ff];
      cur_lvl = tlvl_ff[ch_ff];
      gate    = nlvl_ff | regs_ff[REG_MIXER][3 + ch_ff];
      c_cmb   = $signed({2'b0, cur_cnt}) - $signed({17'b0, ev_ff});
      cf      = cur_per - div_r;
      qodd    = div_q[0];
      new_lvl = qodd ? cur_lvl : ~cur_lvl;
      cnt_s   = {4'b0, cur_cnt};
      per_s   = {4'b0, cur_per};
      cf_s    = {4'b0, cf};
      c_s     = {{2{c_ff[32]}}, c_ff};
      dd      = cf_s - c_s;
      pp      = qodd ? (dd >>> 1) : ((dd - per_s) >>> 1);
      net     = ((gate && cur_lvl) ? cnt_s : 35'sd0)
              + (gate ? pp : 35'sd0)
              + ((!qodd && gate && new_lvl) ? per_s : 35'sd0)
              - ((gate && new_lvl) ? cf_s : 35'sd0);
   end

   // Envelope step
   logic signed [31:0] e_cmb;
   logic [15:0]        env_d;
   logic [5:0]         env_u;
   logic [4:0]         env_step_n;
   logic [3:0]         env_flag_n;
   logic [VOL_W-1:0]   env_vol_n;

   always_comb begin
      e_cmb      = $signed({1'b0, ecnt_ff}) - $signed({16'b0, SUB_STEPS});
      env_d      = {1'b0, div_q} + 16'd1;
      env_u      = {1'b0, estep_ff} - env_d[5:0];
      env_step_n = estep_ff;
      env_flag_n = eflag_ff;
      if (env_d > {11'b0, estep_ff}) begin
         if (eflag_ff[EF_HOLD]) begin
            if (eflag_ff[EF_ALT])
               env_flag_n[EF_ATTACK] = ~eflag_ff[EF_ATTACK];
            env_flag_n[EF_HOLDING] = 1'b1;
            env_step_n = '0;
         end else begin
            if (eflag_ff[EF_ALT] && env_u[5])
               env_flag_n[EF_ATTACK] = ~eflag_ff[EF_ATTACK];
            env_step_n = env_u[4:0];
         end
      end else begin
         env_step_n = estep_ff - env_d[4:0];
      end
      env_vol_n = vol_lookup(env_step_n ^ {5{env_flag_n[EF_ATTACK]}});
   end

   // High-pass output and saturation
   logic [15:0]        mix_sum;
   logic signed [25:0] y_cmb;
   logic signed [15:0] y_sat;

   always_comb begin
      mix_sum = macc_ff[30:15];
      y_cmb   = $signed({10'b0, mix_sum}) - $signed({10'b0, dcx_ff})
              + $signed(mul_ff[DC_SHIFT+25:DC_SHIFT]);
      if (y_cmb > 26'sd32767)
         y_sat = 16'sh7fff;
      else if (y_cmb < -26'sd32768)
         y_sat = -16'sh8000;
      else
         y_sat = y_cmb[15:0];
   end

   // Divider requests
   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = cur_per;
      if (state_ff == S_CH && c_cmb <= 0) begin
         div_start    = 1'b1;
         div_dividend = DIV_W'(-c_cmb);
      end else if (state_ff == S_ENV && !eflag_ff[EF_HOLDING] && e_cmb <= 0) begin
         div_start    = 1'b1;
         div_dividend = DIV_W'(-e_cmb);
         div_divisor  = eper_ff;
      end
   end

   psg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   logic [LFSR_W:0]    lfsr_x;
   logic [15:0]        left_n;

   assign lfsr_x = {1'b0, lfsr_ff} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
   assign left_n = left_ff - ev_ff;

   // Sequencer and state
   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         state_ff <= S_IDLE;
         step_ff  <= init_step;
         for (int i = 0; i < 16; i++) regs_ff[i] <= '0;
         for (int i = 0; i < 3; i++) begin
            tper_ff[i] <= init_per;
            tcnt_ff[i] <= init_per;
            vol_ff[i]  <= '0;
         end
         tlvl_ff   <= '0;
         usenv_ff  <= '0;
         nper_ff   <= init_per;
         ncnt_ff   <= init_per;
         nlvl_ff   <= 1'b1;
         lfsr_ff   <= {{(LFSR_W-1){1'b0}}, 1'b1};
         eper_ff   <= init_eper;
         ecnt_ff   <= init_eper;
         estep_ff  <= 5'd31;
         eflag_ff  <= 4'b0001;
         vol_ff[3] <= VOL_PEAK;
         dcx_ff    <= '0;
         dcy_ff    <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  case (req.action)
                     ACT_WRITE: begin
                        regs_ff[req.reg_addr] <= req.write_data & reg_mask(req.reg_addr);
                        addr_ff  <= req.reg_addr;
                        state_ff <= S_WR_MUL;
                     end
                     ACT_READ: begin
                        res_ff.sample_out <= '0;
                        res_ff.read_data  <= regs_ff[req.reg_addr];
                        res_ff.is_read    <= 1'b1;
                        res_ff.last       <= 1'b1;
                        state_ff          <= S_EMIT;
                     end
                     ACT_RENDER: begin
                        if (burst_n != '0) begin
                           for (int i = 0; i < 3; i++) begin
                              if ((regs_ff[REG_MIXER][i] || regs_ff[8 + i][4:0] == '0)
                                  && tcnt_ff[i] <= {9'b0, burst_len})
                                 tcnt_ff[i] <= tcnt_ff[i] + {9'b0, burst_len};
                              if (regs_ff[REG_MIXER][i])
                                 tlvl_ff[i] <= 1'b1;
                           end
                           if (regs_ff[REG_MIXER][5:3] == 3'b111
                               && ncnt_ff <= {9'b0, burst_len})
                              ncnt_ff <= ncnt_ff + {9'b0, burst_len};
                           burst_ff <= burst_n;
                           left_ff  <= SUB_STEPS;
                           for (int i = 0; i < 3; i++) area_ff[i] <= '0;
                           state_ff <= S_EV;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_WR_MUL: state_ff <= S_WR_APPLY;
            S_WR_APPLY: begin
               case (addr_ff) inside
                  [4'd0:4'd5]: begin
                     tper_ff[addr_ff[2:1]] <= tone_p;
                     tcnt_ff[addr_ff[2:1]] <= retune_count(tcnt_ff[addr_ff[2:1]],
                                                           tper_ff[addr_ff[2:1]], tone_p);
                  end
                  REG_NOISE: begin
                     nper_ff <= tone_p;
                     ncnt_ff <= retune_count(ncnt_ff, nper_ff, tone_p);
                  end
                  [4'd8:4'd10]: begin
                     usenv_ff[addr_ff[1:0]] <= vol_reg[4];
                     if (vol_reg[4])
                        vol_ff[addr_ff[1:0]] <= vol_ff[3];
                     else if (vol_reg == '0)
                        vol_ff[addr_ff[1:0]] <= vol_lookup(5'd0);
                     else
                        vol_ff[addr_ff[1:0]] <= vol_lookup({vol_reg[3:0], 1'b1});
                  end
                  REG_ENV_LO, REG_ENV_HI: begin
                     eper_ff <= env_p;
                     ecnt_ff <= retune_count(ecnt_ff, eper_ff, env_p);
                  end
                  REG_SHAPE: begin
                     eflag_ff <= shape_flags;
                     ecnt_ff  <= eper_ff;
                     estep_ff <= 5'd31;
                     vol_ff[3] <= vol_lookup(5'd31 ^ {5{shape_flags[EF_ATTACK]}});
                     for (int i = 0; i < 3; i++)
                        if (usenv_ff[i])
                           vol_ff[i] <= vol_lookup(5'd31 ^ {5{shape_flags[EF_ATTACK]}});
                  end
                  default: ;
               endcase
               state_ff <= S_IDLE;
            end
            S_EV: begin
               ev_ff    <= (ncnt_ff < {15'b0, left_ff}) ? ncnt_ff[15:0] : left_ff;
               ch_ff    <= '0;
               state_ff <= S_CH;
            end
            S_CH: begin
               if (c_cmb > 0) begin
                  tcnt_ff[ch_ff] <= c_cmb[PER_W-1:0];
                  if (gate && cur_lvl)
                     area_ff[ch_ff] <= area_ff[ch_ff] + AREA_W'(ev_ff);
                  if (ch_ff == 2'd2)
                     state_ff <= S_NOISE;
                  else
                     ch_ff <= ch_ff + 1'b1;
               end else begin
                  c_ff     <= c_cmb;
                  state_ff <= S_CH_DIV;
               end
            end
            S_CH_DIV: begin
               if (div_done) begin
                  tcnt_ff[ch_ff] <= cf;
                  tlvl_ff[ch_ff] <= new_lvl;
                  area_ff[ch_ff] <= area_ff[ch_ff] + net[AREA_W-1:0];
                  if (ch_ff == 2'd2) begin
                     state_ff <= S_NOISE;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     state_ff <= S_CH;
                  end
               end
            end
            S_NOISE: begin
               if (ncnt_ff == {15'b0, ev_ff}) begin
                  nlvl_ff <= nlvl_ff ^ lfsr_ff[0] ^ lfsr_ff[1];
                  lfsr_ff <= lfsr_x[LFSR_W:1];
                  ncnt_ff <= nper_ff;
               end else begin
                  ncnt_ff <= ncnt_ff - {15'b0, ev_ff};
               end
               left_ff  <= left_n;
               state_ff <= (left_n != '0) ? S_EV : S_ENV;
            end
            S_ENV: begin
               mix_ff  <= '0;
               macc_ff <= '0;
               if (eflag_ff[EF_HOLDING]) begin
                  state_ff <= S_MIX;
               end else if (e_cmb > 0) begin
                  ecnt_ff  <= e_cmb[PER_W-1:0];
                  state_ff <= S_MIX;
               end else begin
                  state_ff <= S_ENV_DIV;
               end
            end
            S_ENV_DIV: begin
               if (div_done) begin
                  ecnt_ff   <= eper_ff - div_r;
                  estep_ff  <= env_step_n;
                  eflag_ff  <= env_flag_n;
                  vol_ff[3] <= env_vol_n;
                  for (int i = 0; i < 3; i++)
                     if (usenv_ff[i]) vol_ff[i] <= env_vol_n;
                  state_ff <= S_MIX;
               end
            end
            S_MIX: begin
               // product of the previous voice is registered, so it lands in the next cycle
               if (mix_ff != '0)
                  macc_ff <= macc_ff + mul_ff[31:0];
               if (mix_ff == 2'd3)
                  state_ff <= S_DC;
               else
                  mix_ff <= mix_ff + 1'b1;
            end
            S_DC: state_ff <= S_DCY;
            S_DCY: begin
               dcx_ff            <= mix_sum;
               dcy_ff            <= y_cmb[23:0];
               res_ff.sample_out <= y_sat;
               res_ff.read_data  <= '0;
               res_ff.is_read    <= 1'b0;
               res_ff.last       <= (burst_ff == BURST_W'(1));
               state_ff          <= S_EMIT;
            end
            S_EMIT: begin
               if (res_ready) begin
                  if (res_ff.last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     burst_ff <= burst_ff - 1'b1;
                     left_ff  <= SUB_STEPS;
                     for (int i = 0; i < 3; i++) area_ff[i] <= '0;
                     state_ff <= S_EV;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_EMIT);
   assign res       = res_ff;

endmodule

[hw/rtl/psg_three_voice_sound_generator_top.sv]
// Top level of the three-voice sound generator: stream ports and output register.
//
// Usage: items enter on the req_ channel. req_tuser selects the action (write register,
// read register, render samples); req_tdata carries register number, write byte and
// sample count. A write gives no item back, a read gives one item with rsp_tuser high,
// a render gives one signed 16-bit sample per count (capped at MAX_BURST), the final one
// with rsp_tlast high. csr_wr_en loads the period scale and restarts all other state.
// Sequence: a write passes S_WR_MUL and S_WR_APPLY, a read goes to S_EMIT. Each sample
// walks its noise events one by one, about 32768 / noise period of them; each event
// runs S_EV, S_CH for each voice and S_NOISE, plus the shared 15-step divider for every
// voice whose counter wraps; a sample adds envelope, mixing, filter and output through the
// one shared multiplier, plus the divider when the envelope steps. A slow noise source
// keeps a sample short; a noise period of one (scale of one) makes it very long.
// Reset (or a scale write) returns the sound registers and counters to their start values,
// periods set by the scale. A stalled receiver holds the output register; the sequencer
// waits with the next sample, and req_tready rises again once the last item is registered.
module psg_three_voice_sound_generator_top import psg_pkg::*; #(
   parameter int MAX_BURST = MAX_BURST_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,   // update_step
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,     // action
   input  logic [23:0] req_tdata,     // reg_addr[3:0], write_data[11:4], sample_count[18:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,     // is_read
   output logic [23:0] rsp_tdata,     // sample_out[15:0], read_data[23:16]
   output logic        rsp_tlast      // last
);

   req_item_type req;
   rsp_item_type core_res;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         core_idle;
   logic         core_valid;
   logic         core_ready;

   always_comb begin
      req.action       = req_tuser;
      req.reg_addr     = req_tdata[3:0];
      req.write_data   = req_tdata[11:4];
      req.sample_count = req_tdata[18:12];
   end

   assign req_tready = core_idle;
   assign core_ready = !rsp_valid_ff || rsp_tready;

   psg_core #(.MAX_BURST(MAX_BURST)) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .start       (req_tvalid && core_idle),
      .req         (req),
      .idle        (core_idle),
      .res_valid   (core_valid),
      .res_ready   (core_ready),
      .res         (core_res)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_valid && core_ready) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= core_res;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.is_read;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {rsp_ff.read_data, rsp_ff.sample_out};

endmodule

[bench/psg_checker.sv]
// Checker for the sound generator: models the block, watches both channels and counts mismatches.
module psg_checker import psg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        rsp_tuser,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BURST_CAP = 64;
   localparam longint INT_MAX = 64'sd2147483647;
   localparam longint INT_MIN = -64'sd2147483648;

   // Model state
   logic [15:0]  scale;
   logic [7:0]   regs [16];
   int           tper [3];
   int           tcnt [3];
   bit           tlev [3];
   int           nper, ncnt;
   bit           nlev;
   logic [16:0]  lfsr;
   int           eper, ecnt, estep;
   logic [3:0]   eflags;
   int           vols [4];
   bit           use_env [3];
   int           dc_in, dc_out;

   rsp_item_type expected_q [$];

   function automatic int vtab(input int i);
      return int'(vol_lookup(5'(i)));
   endfunction

   function automatic int clamp(input longint v, input longint lo);
      if (v < lo) return int'(lo);
      if (v > INT_MAX) return int'(INT_MAX);
      return int'(v);
   endfunction

   function automatic int env_level();
      int att;
      att = eflags[EF_ATTACK] ? 31 : 0;
      return vtab((estep ^ att) & 31);
   endfunction

   function automatic void share_env();
      for (int i = 0; i < 3; i++)
         if (use_env[i]) vols[i] = vols[3];
   endfunction

   // Period or volume update after a register write
   function automatic void apply_write(input int a);
      longint p;
      int ch, r, old;
      case (a)
         0, 1, 2, 3, 4, 5: begin
            ch = a >> 1;
            regs[ch*2+1] &= 8'h0f;
            p = longint'(regs[ch*2] + 256 * regs[ch*2+1]) * scale;
            if (p == 0) p = scale;
            old = tper[ch];
            tper[ch] = clamp(p, 1);
            tcnt[ch] = clamp(longint'(tcnt[ch]) + tper[ch] - old, 1);
         end
         REG_NOISE: begin
            regs[6] &= 8'h1f;
            p = longint'(regs[6]) * scale;
            if (p == 0) p = scale;
            old = nper;
            nper = clamp(p, 1);
            ncnt = clamp(longint'(ncnt) + nper - old, 1);
         end
         8, 9, 10: begin
            ch = a - 8;
            regs[a] &= 8'h1f;
            r = regs[a];
            use_env[ch] = r[4];
            vols[ch] = use_env[ch] ? vols[3] : vtab(r != 0 ? (r * 2 + 1) & 31 : 0);
         end
         REG_ENV_LO, REG_ENV_HI: begin
            p = longint'(regs[11] + 256 * regs[12]) * scale;
            if (p == 0) p = scale / 2;
            old = eper;
            eper = clamp(p, 1);
            ecnt = clamp(longint'(ecnt) + eper - old, 1);
         end
         REG_SHAPE: begin
            regs[13] &= 8'h0f;
            r = regs[13];
            eflags = 0;
            eflags[EF_ATTACK] = r[2];
            if (!r[3]) begin
               eflags[EF_HOLD] = 1;
               eflags[EF_ALT] = r[2];
            end else begin
               eflags[EF_HOLD] = r[0];
               eflags[EF_ALT] = r[1];
            end
            ecnt = eper;
            estep = 31;
            vols[3] = env_level();
            share_env();
         end
         default: ;
      endcase
   endfunction

   function automatic void restart();
      for (int i = 0; i < 16; i++) regs[i] = 0;
      for (int i = 0; i < 3; i++) begin
         tper[i] = 0; tcnt[i] = 0; tlev[i] = 0; use_env[i] = 0;
      end
      for (int i = 0; i < 4; i++) vols[i] = 0;
      nper = 0; ncnt = 0; eper = 0; ecnt = 0;
      nlev = 1; lfsr = 1; estep = 0; eflags = 0;
      dc_in = 0; dc_out = 0;
      for (int i = 0; i < 14; i++) apply_write(i);
   endfunction

   // High-time area of one voice over one noise interval
   function automatic longint tone_area(input int ch, input int ev, input bit gate);
      longint area;
      int cnt, per;
      area = 0;
      cnt = tcnt[ch];
      per = tper[ch];
      if (gate && tlev[ch]) area += cnt;
      cnt -= ev;
      while (cnt <= 0) begin
         cnt += per;
         if (cnt > 0) begin
            tlev[ch] ^= 1;
            if (gate && tlev[ch]) area += per;
            break;
         end
         cnt += per;
         if (gate) area += per;
      end
      if (gate && tlev[ch]) area -= cnt;
      tcnt[ch] = cnt;
      return area;
   endfunction

   function automatic void env_advance();
      longint d, nxt;
      int u;
      if (eflags[EF_HOLDING]) return;
      ecnt -= 32768;
      if (ecnt > 0) return;
      d = (-longint'(ecnt)) / eper + 1;
      ecnt = int'(longint'(ecnt) + d * eper);
      nxt = longint'(estep) - d;
      if (nxt < 0) begin
         if (eflags[EF_HOLD]) begin
            if (eflags[EF_ALT]) eflags[EF_ATTACK] ^= 1;
            eflags[EF_HOLDING] = 1;
            estep = 0;
         end else begin
            u = int'((longint'(estep) - d) & 63);
            if (eflags[EF_ALT] && u[5]) eflags[EF_ATTACK] ^= 1;
            estep = u & 31;
         end
      end else
         estep = int'(nxt);
      vols[3] = env_level();
      share_env();
   endfunction

   function automatic logic [15:0] next_sample();
      longint area [3];
      longint sum, prod, fb, y;
      int left, ev;
      bit gate;
      area = '{0, 0, 0};
      left = 32768;
      do begin
         ev = ncnt < left ? ncnt : left;
         for (int ch = 0; ch < 3; ch++) begin
            gate = nlev || regs[7][3+ch];
            area[ch] += tone_area(ch, ev, gate);
         end
         ncnt -= ev;
         if (ncnt <= 0) begin
            if (lfsr[0] ^ lfsr[1]) nlev ^= 1;
            // taps reach one bit above the register before the shift
            if (lfsr[0]) lfsr = 17'(({1'b0, lfsr} ^ LFSR_TAPS) >> 1);
            else lfsr = lfsr >> 1;
            ncnt += nper;
         end
         left -= ev;
      end while (left > 0);
      env_advance();
      sum = (area[0] * vols[0] + area[1] * vols[1] + area[2] * vols[2]) / 32768;
      prod = longint'(dc_out) * 4076;
      if (prod >= 0) fb = prod >>> DC_SHIFT;
      else fb = -((-prod + 4095) >>> DC_SHIFT);
      y = sum - dc_in + fb;
      dc_in = clamp(sum, INT_MIN);
      dc_out = clamp(y, INT_MIN);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      return 16'(y);
   endfunction

   // Expected items for one accepted input item
   function automatic void predict_item(input logic [1:0] act, input logic [23:0] d);
      int addr, n, len;
      rsp_item_type e;
      addr = d[3:0];
      n = d[18:12];
      if (act == ACT_WRITE) begin
         regs[addr] = d[11:4];
         apply_write(addr);
      end else if (act == ACT_READ) begin
         e = '{sample_out: 0, read_data: regs[addr], is_read: 1, last: 1};
         expected_q.push_back(e);
      end else if (act == ACT_RENDER && n != 0) begin
         if (n > BURST_CAP) n = BURST_CAP;
         len = n * 32768;
         for (int i = 0; i < 3; i++) begin
            if (regs[7][i] || regs[8+i][4:0] == 0)
               if (tcnt[i] <= len) tcnt[i] += len;
            if (regs[7][i]) tlev[i] = 1;
         end
         if ((regs[7] & 8'h38) == 8'h38 && ncnt <= len) ncnt += len;
         for (int k = 0; k < n; k++) begin
            e = '{sample_out: next_sample(), read_data: 0, is_read: 0, last: k + 1 == n};
            expected_q.push_back(e);
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type e;
      if (reset) begin
         scale = STEP_RESET;
         restart();
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            scale = csr_wr_data == 0 ? 16'd1 : csr_wr_data;
            restart();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result item %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_tdata[15:0] !== e.sample_out || rsp_tdata[23:16] !== e.read_data
                   || rsp_tuser !== e.is_read || rsp_tlast !== e.last)
                  fail_count <= fail_count + 1;
               if (rsp_tdata[15:0] !== e.sample_out)
                  $error("sample_out: expected %0d, got %0d", $signed(e.sample_out),
                         $signed(rsp_tdata[15:0]));
               if (rsp_tdata[23:16] !== e.read_data)
                  $error("read_data: expected %h, got %h", e.read_data, rsp_tdata[23:16]);
               if (rsp_tuser !== e.is_read)
                  $error("is_read: expected %b, got %b", e.is_read, rsp_tuser);
               if (rsp_tlast !== e.last)
                  $error("last: expected %b, got %b", e.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
      end
      pending = expected_q.size();
   end
endmodule

[bench/testbench.sv]
// Top of the sound generator bench: clock, reset, stimulus and verdict.
module testbench import psg_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // A sample with a noise period of one can run very long
   localparam int STALL_LIMIT = 8000000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [15:0] csr_wr_data = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [1:0]  req_tuser = 0;
   logic [23:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic        rsp_tuser;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count, pending;
   int          send_idle_pct, recv_idle_pct;
   int          quiet_cycles;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   psg_three_voice_sound_generator_top dut (.*);
   psg_checker chk (.*);

   // Receiver stall pattern
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("psg_three_voice_sound_generator_top regression: fail");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] act, input logic [3:0] addr,
                            input logic [7:0] wd, input logic [6:0] cnt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= act;
      req_tdata <= {5'd0, cnt, wd, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_scale(input logic [15:0] v);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   // Random writes and reads, renders that are mostly short, and the unused action
   task automatic random_item();
      int r;
      logic [6:0] cnt;
      r = $urandom_range(99);
      cnt = ($urandom_range(19) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 4));
      if (r < 45)
         send_item(ACT_WRITE, 4'($urandom_range(15)), 8'($urandom), 7'($urandom));
      else if (r < 60)
         send_item(ACT_READ, 4'($urandom_range(15)), 8'($urandom), 7'($urandom));
      else if (r < 95)
         send_item(ACT_RENDER, 4'($urandom), 8'($urandom), cnt);
      else
         send_item(ACT_UNUSED, 4'($urandom), 8'($urandom), 7'($urandom));
   endtask

   initial begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reads after reset, tone and noise setup, envelope shapes, burst limits
      send_item(ACT_READ, 4'd0, 8'h00, 7'd0);
      send_item(ACT_RENDER, 4'd0, 8'h00, 7'd0);
      send_item(ACT_RENDER, 4'd0, 8'h00, 7'd1);
      send_item(ACT_WRITE, 4'd0, 8'hff, 7'd0);
      send_item(ACT_WRITE, 4'd1, 8'hff, 7'd0);
      send_item(ACT_READ, 4'd1, 8'h00, 7'd0);
      send_item(ACT_WRITE, 4'd2, 8'h40, 7'd0);
      send_item(ACT_WRITE, REG_NOISE, 8'h01, 7'd0);
      send_item(ACT_WRITE, REG_MIXER, 8'h30, 7'd0);
      send_item(ACT_WRITE, REG_VOL_A, 8'h0f, 7'd0);
      send_item(ACT_WRITE, 4'd9, 8'h1f, 7'd0);
      send_item(ACT_WRITE, 4'd10, 8'hff, 7'd0);
      send_item(ACT_WRITE, REG_ENV_LO, 8'h01, 7'd0);
      send_item(ACT_WRITE, REG_ENV_HI, 8'h00, 7'd0);
      send_item(ACT_WRITE, REG_SHAPE, 8'h0e, 7'd0);
      send_item(ACT_RENDER, 4'd0, 8'h00, 7'd64);
      send_item(ACT_WRITE, REG_SHAPE, 8'h04, 7'd0);
      send_item(ACT_RENDER, 4'd0, 8'h00, 7'd127);
      send_item(ACT_WRITE, REG_ENV_HI, 8'hff, 7'd0);
      send_item(ACT_WRITE, REG_MIXER, 8'h3f, 7'd0);
      send_item(ACT_RENDER, 4'd0, 8'h00, 7'd3);
      send_item(ACT_UNUSED, 4'd15, 8'hff, 7'd127);
      send_item(ACT_READ, 4'd15, 8'h00, 7'd0);
      // Sender waits for all results before the next phase
      drain();
      set_scale(16'd0);
      send_item(ACT_WRITE, 4'd0, 8'h05, 7'd0);
      send_item(ACT_RENDER, 4'd0, 8'h00, 7'd8);
      set_scale(16'hffff);
      send_item(ACT_WRITE, REG_ENV_HI, 8'hff, 7'd0);
      send_item(ACT_WRITE, REG_SHAPE, 8'h0a, 7'd0);
      send_item(ACT_RENDER, 4'd0, 8'h00, 7'd8);
      set_scale(16'd7710);

      // Random phases with three idling patterns and a few scales
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 13 : ph == 1 ? 84 : 0;
         recv_idle_pct = ph == 0 ? 84 : ph == 1 ? 13 : 0;
         for (int i = 0; i < 150; i++) begin
            random_item();
            if (i == 75) set_scale(16'($urandom_range(1, 20000)));
         end
         set_scale(ph == 1 ? 16'd1 : 16'($urandom_range(2000, 12000)));
      end

      drain();
      if (fail_count == 0)
         $display("psg_three_voice_sound_generator_top regression: pass");
      else
         $display("psg_three_voice_sound_generator_top regression: fail");
      $finish;
   end
endmodule
